@@ hw/rtl/pal_pkg.sv @@
// ----------------------------------------------------------------------------
// Positional array list package
// Operation, status and cell command codes shared by the list modules.
// ----------------------------------------------------------------------------
package pal_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_BACK = 3'd0,
    OP_POP_BACK  = 3'd1,
    OP_POP_FRONT = 3'd2,
    OP_INSERT    = 3'd3,
    OP_DELETE    = 3'd4,
    OP_FIND      = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_EMPTY     = 3'd2,
    STATUS_BAD_POS   = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_FIND   = 2'd3
  } cell_op_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } ctl_state_e;

  typedef struct packed {
    cell_op_e    op;
    logic [31:0] value;
  } cell_cmd_t;

endpackage

@@ hw/rtl/pal_cell.sv @@
// ----------------------------------------------------------------------------
// Positional array list cell
// Holds one list entry and its match flag, shifting with its neighbors.
// ----------------------------------------------------------------------------
module pal_cell #(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  logic               clk_i,
  input  pal_pkg::cell_cmd_t cmd_i,
  input  logic [CNT_W-1:0]   pos_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic [31:0]        prev_i,
  input  logic [31:0]        next_i,
  output logic [31:0]        entry_o,
  output logic               match_o
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic [31:0] entry_q, entry_d;
  logic        match_q, match_d;

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    case (cmd_i.op)
      pal_pkg::CELL_INSERT: begin
        if (MY_IDX > pos_i) begin
          entry_d = prev_i;
        end else if (MY_IDX == pos_i) begin
          entry_d = cmd_i.value;
        end
      end
      pal_pkg::CELL_DELETE: begin
        if (MY_IDX >= pos_i) begin
          entry_d = next_i;
        end
      end
      pal_pkg::CELL_FIND: begin
        match_d = (entry_q == cmd_i.value) && (MY_IDX < count_i);
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

@@ hw/rtl/pal_find_tree.sv @@
// ----------------------------------------------------------------------------
// Positional array list find tree
// Registered priority tree that picks the lowest matching cell index.
// ----------------------------------------------------------------------------
module pal_find_tree #(
  parameter int N = 64
) (
  input  logic                 clk_i,
  input  logic [N-1:0]         match_i,
  output logic                 hit_o,
  output logic [$clog2(N)-1:0] index_o
);

  localparam int LEVELS = $clog2(N);
  localparam int IDX_W  = LEVELS;
  localparam int N2     = 1 << LEVELS;

  logic             leaf_hit [N2];
  logic [IDX_W-1:0] leaf_idx [N2];
  logic             node_hit_q [1:N2-1];
  logic [IDX_W-1:0] node_idx_q [1:N2-1];

  for (genvar k = 0; k < N2; k++) begin : g_leaf
    if (k < N) begin : g_real
      assign leaf_hit[k] = match_i[k];
    end else begin : g_pad
      assign leaf_hit[k] = 1'b0;
    end
    assign leaf_idx[k] = IDX_W'(k);
  end

  for (genvar n = 1; n < N2; n++) begin : g_node
    logic             lo_hit, hi_hit;
    logic [IDX_W-1:0] lo_idx, hi_idx;
    if (2 * n >= N2) begin : g_from_leaf
      assign lo_hit = leaf_hit[2 * n - N2];
      assign hi_hit = leaf_hit[2 * n + 1 - N2];
      assign lo_idx = leaf_idx[2 * n - N2];
      assign hi_idx = leaf_idx[2 * n + 1 - N2];
    end else begin : g_from_node
      assign lo_hit = node_hit_q[2 * n];
      assign hi_hit = node_hit_q[2 * n + 1];
      assign lo_idx = node_idx_q[2 * n];
      assign hi_idx = node_idx_q[2 * n + 1];
    end
    always_ff @(posedge clk_i) begin
      node_hit_q[n] <= lo_hit | hi_hit;
      node_idx_q[n] <= lo_hit ? lo_idx : hi_idx;
    end
  end

  assign hit_o   = node_hit_q[1];
  assign index_o = node_idx_q[1];

endmodule

@@ hw/rtl/positional_array_list.sv @@
// ----------------------------------------------------------------------------
// Positional array list
// Packed ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Each accepted word is one list operation and returns one result word with
// a status and the element count. Push, pop, insert and delete show their
// result in the next cycle, since every cell shifts toward or away from its
// neighbor at once. In a find, all cells first compare and register their
// match flags, a registered priority tree of $clog2(CAPACITY) levels then
// picks the lowest matching position, and the result word is registered.
// One operation is in work at a time, and a new word is taken while no
// result waits or as the waiting result is taken.
module positional_array_list #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [6:0]  position_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [5:0]  found_index_o,
  output logic [6:0]  count_o
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LEVELS = $clog2(CAPACITY);
  localparam int IDX_W  = LEVELS;
  localparam int WAIT_W = $clog2(LEVELS + 1);
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [WAIT_W-1:0] WAIT_MAX = WAIT_W'(LEVELS);

  pal_pkg::ctl_state_e state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [WAIT_W-1:0]   wait_q, wait_d;

  logic                out_valid_q;
  logic [2:0]          out_status_q, out_status_d;
  logic [5:0]          out_found_q, out_found_d;
  logic [6:0]          out_count_q, out_count_d;
  logic                load_out;

  pal_pkg::cell_cmd_t  cmd;
  logic [CNT_W-1:0]    cell_pos;
  logic                in_ready;
  logic                accept;
  logic [CMP_W-1:0]    pos_ext, cnt_ext;
  logic                full, empty;

  logic [31:0]         entry_w [CAPACITY];
  logic [CAPACITY-1:0] match_w;
  logic                tree_hit;
  logic [IDX_W-1:0]    tree_idx;
  logic [IDX_W+5:0]    found_wide;
  logic [CNT_W+6:0]    count_wide;

  assign pos_ext     = CMP_W'(position_i);
  assign cnt_ext     = CMP_W'(count_q);
  assign full        = (count_q == CAP_CNT);
  assign empty       = (count_q == '0);
  assign in_ready    = (state_q == pal_pkg::S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready;
  assign found_wide  = {6'b0, tree_idx};
  assign count_wide  = {7'b0, count_d};
  assign out_count_d = count_wide[6:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pal_pkg::S_IDLE: begin
        if (accept && (pal_pkg::op_e'(opcode_i) == pal_pkg::OP_FIND)) begin
          state_d = pal_pkg::S_SEARCH;
        end
      end
      pal_pkg::S_SEARCH: begin
        if (wait_q == '0) begin
          state_d = pal_pkg::S_IDLE;
        end
      end
      default: state_d = pal_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = pal_pkg::CELL_HOLD;
    cmd.value    = value_i;
    cell_pos     = '0;
    count_d      = count_q;
    wait_d       = wait_q;
    load_out     = 1'b0;
    out_status_d = pal_pkg::STATUS_OK;
    out_found_d  = '0;
    unique case (state_q)
      pal_pkg::S_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          unique case (pal_pkg::op_e'(opcode_i))
            pal_pkg::OP_PUSH_BACK: begin
              if (full) begin
                out_status_d = pal_pkg::STATUS_FULL;
              end else begin
                cmd.op   = pal_pkg::CELL_INSERT;
                cell_pos = count_q;
                count_d  = count_q + 1'b1;
              end
            end
            pal_pkg::OP_POP_BACK: begin
              if (empty) begin
                out_status_d = pal_pkg::STATUS_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            pal_pkg::OP_POP_FRONT: begin
              if (empty) begin
                out_status_d = pal_pkg::STATUS_EMPTY;
              end else begin
                cmd.op  = pal_pkg::CELL_DELETE;
                count_d = count_q - 1'b1;
              end
            end
            pal_pkg::OP_INSERT: begin
              if (full) begin
                out_status_d = pal_pkg::STATUS_FULL;
              end else if (pos_ext > cnt_ext) begin
                out_status_d = pal_pkg::STATUS_BAD_POS;
              end else begin
                cmd.op   = pal_pkg::CELL_INSERT;
                cell_pos = CNT_W'(position_i);
                count_d  = count_q + 1'b1;
              end
            end
            pal_pkg::OP_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                out_status_d = pal_pkg::STATUS_BAD_POS;
              end else begin
                cmd.op   = pal_pkg::CELL_DELETE;
                cell_pos = CNT_W'(position_i);
                count_d  = count_q - 1'b1;
              end
            end
            pal_pkg::OP_FIND: begin
              cmd.op   = pal_pkg::CELL_FIND;
              wait_d   = WAIT_MAX;
              load_out = 1'b0;
            end
            default: begin
              out_status_d = pal_pkg::STATUS_OK;
            end
          endcase
        end
      end
      pal_pkg::S_SEARCH: begin
        if (wait_q == '0) begin
          load_out = 1'b1;
          if (tree_hit) begin
            out_status_d = pal_pkg::STATUS_OK;
            out_found_d  = found_wide[5:0];
          end else begin
            out_status_d = pal_pkg::STATUS_NOT_FOUND;
          end
        end else begin
          wait_d = wait_q - 1'b1;
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pal_pkg::S_IDLE;
      count_q     <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wait_q  <= wait_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
      out_count_q  <= out_count_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = value_i;
    end else begin : g_prev
      assign prev_w = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = entry_w[i];
    end else begin : g_next
      assign next_w = entry_w[i+1];
    end
    pal_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (cell_pos),
      .count_i (count_q),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .entry_o (entry_w[i]),
      .match_o (match_w[i])
    );
  end

  pal_find_tree #(
    .N (CAPACITY)
  ) u_find_tree (
    .clk_i   (clk_i),
    .match_i (match_w),
    .hit_o   (tree_hit),
    .index_o (tree_idx)
  );

  assign in_ready_o    = in_ready;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_index_o = out_found_q;
  assign count_o       = out_count_q;

endmodule

@@ tb/positional_array_list_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list checker
// Watches both channels of the list block and keeps its own copy of the list.
// Every accepted operation word updates that copy and queues the status,
// found index and count it should produce. Every accepted result word is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module positional_array_list_checker
  import pal_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  opcode_i,
  input  logic [6:0]  position_i,
  input  logic [31:0] value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [5:0]  found_index_i,
  input  logic [6:0]  count_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] found_index;
    logic [6:0] count;
  } list_result_t;

  logic [31:0]  list_vals [CAPACITY];
  int           list_len;
  list_result_t result_q [$];
  int           fail_n;

  function automatic list_result_t apply_list_op(input op_e op, input int pos,
                                                 input logic [31:0] val);
    list_result_t r;
    int k;
    r.status      = STATUS_OK;
    r.found_index = '0;
    case (op)
      OP_PUSH_BACK: begin
        if (list_len >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          list_vals[list_len] = val;
          list_len++;
        end
      end
      OP_POP_BACK: begin
        if (list_len == 0) r.status = STATUS_EMPTY;
        else list_len--;
      end
      OP_POP_FRONT: begin
        if (list_len == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          for (k = 0; k < list_len - 1; k++) list_vals[k] = list_vals[k + 1];
          list_len--;
        end
      end
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else if (pos > list_len) begin
          r.status = STATUS_BAD_POS;
        end else begin
          for (k = list_len; k > pos; k--) list_vals[k] = list_vals[k - 1];
          list_vals[pos] = val;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (pos >= list_len) begin
          r.status = STATUS_BAD_POS;
        end else begin
          for (k = pos; k < list_len - 1; k++) list_vals[k] = list_vals[k + 1];
          list_len--;
        end
      end
      OP_FIND: begin
        r.status = STATUS_NOT_FOUND;
        for (k = list_len - 1; k >= 0; k--) begin
          if (list_vals[k] == val) begin
            r.status      = STATUS_OK;
            r.found_index = k[5:0];
          end
        end
      end
      default: ;
    endcase
    r.count = list_len[6:0];
    return r;
  endfunction

  task automatic report_field(input string name, input int exp_v, input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
    fail_n++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_r;
    if (!rst_ni) begin
      list_len     = 0;
      fail_n       = 0;
      result_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual status %0d count %0d",
                   $realtime, status_i, count_i);
          fail_n++;
        end else begin
          exp_r = result_q.pop_front();
          if (status_i !== exp_r.status) report_field("status", exp_r.status, status_i);
          if (found_index_i !== exp_r.found_index)
            report_field("found_index", exp_r.found_index, found_index_i);
          if (count_i !== exp_r.count) report_field("count", exp_r.count, count_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        result_q.push_back(apply_list_op(op_e'(opcode_i), int'(position_i), value_i));
      end
      fail_count_o <= fail_n;
      pending_o    <= result_q.size();
    end
  end

endmodule

@@ tb/positional_array_list_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list testbench
// Drives list operations into the block and lets the checker judge results.
// A directed opening covers empty, bad position, duplicate and extreme value
// cases; random phases then grow, shrink and search the list, filling it to
// capacity, under random idling on both channels and a long stall.
// ----------------------------------------------------------------------------
module positional_array_list_tb;
  import pal_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_WORDS = 1050;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN,
    MIX_SEARCH
  } mix_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i    = '0;
  logic [6:0]  position_i  = '0;
  logic [31:0] value_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [5:0]  found_index_o;
  logic [6:0]  count_o;

  int          fail_count;
  int          pending;
  int          cycle_n = 0;
  int          est_len = 0;
  int          num_words = 0;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  logic [31:0] value_pool [8];

  positional_array_list #(.CAPACITY(CAPACITY)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .count_o       (count_o)
  );

  positional_array_list_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .opcode_i      (opcode_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .found_index_i (found_index_o),
    .count_i       (count_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("** positional_array_list: FAILED **");
      $finish;
    end
  end

  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  task automatic send_word(input op_e op, input int pos, input logic [31:0] val);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    position_i <= pos[6:0];
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    num_words++;
    case (op)
      OP_PUSH_BACK: if (est_len < CAPACITY) est_len++;
      OP_POP_BACK, OP_POP_FRONT: if (est_len > 0) est_len--;
      OP_INSERT: if (est_len < CAPACITY && pos <= est_len) est_len++;
      OP_DELETE: if (pos < est_len) est_len--;
      default: ;
    endcase
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 65) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic op_e pick_op(input mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 45) return OP_PUSH_BACK;
        if (r < 80) return OP_INSERT;
        if (r < 88) return OP_FIND;
        if (r < 93) return OP_POP_BACK;
        if (r < 97) return OP_POP_FRONT;
        return OP_DELETE;
      end
      MIX_SHRINK: begin
        if (r < 30) return OP_POP_BACK;
        if (r < 55) return OP_POP_FRONT;
        if (r < 85) return OP_DELETE;
        if (r < 92) return OP_PUSH_BACK;
        return OP_FIND;
      end
      MIX_SEARCH: begin
        if (r < 50) return OP_FIND;
        return op_e'($urandom_range(0, 5));
      end
      default: return op_e'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic int pick_position(input op_e op);
    if ($urandom_range(0, 99) < 20) return $urandom_range(0, 64);
    if (op == OP_INSERT) return $urandom_range(0, est_len);
    if (op == OP_DELETE && est_len > 0) return $urandom_range(0, est_len - 1);
    return $urandom_range(0, 64);
  endfunction

  initial begin
    mix_e mix;
    op_e  op;
    int   phase_len;
    bit   first_phase;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    value_pool[4] = 32'h0000_0001;
    value_pool[5] = $urandom;
    value_pool[6] = $urandom;
    value_pool[7] = $urandom;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list cases first, then extremes, duplicates and edge positions.
    send_word(OP_POP_BACK, 0, 32'h0);
    send_word(OP_POP_FRONT, 0, 32'h0);
    send_word(OP_DELETE, 0, 32'h0);
    send_word(OP_FIND, 0, 32'h0);
    send_word(OP_INSERT, 1, 32'h1);
    send_word(OP_INSERT, 0, 32'h7FFF_FFFF);
    send_word(OP_PUSH_BACK, 0, 32'h8000_0000);
    send_word(OP_PUSH_BACK, 64, 32'h0000_0000);
    send_word(OP_PUSH_BACK, 0, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 4, 32'h0000_0005);
    send_word(OP_INSERT, 0, 32'hFFFF_FFFF);
    send_word(OP_FIND, 0, 32'hFFFF_FFFF);
    send_word(OP_FIND, 0, 32'h8000_0000);
    send_word(OP_FIND, 0, 32'h0000_0005);
    send_word(OP_FIND, 0, 32'h0000_3039);
    send_word(OP_DELETE, 6, 32'h0);
    send_word(OP_DELETE, 64, 32'h0);
    send_word(OP_INSERT, 64, 32'h0);
    send_word(OP_DELETE, 0, 32'h0);
    send_word(OP_FIND, 0, 32'hFFFF_FFFF);
    send_word(OP_POP_FRONT, 0, 32'h0);
    send_word(OP_POP_BACK, 0, 32'h0);
    send_word(OP_DELETE, 1, 32'h0);
    send_word(OP_INSERT, 1, 32'h5555_5555);
    send_word(OP_FIND, 0, 32'hAAAA_AAAA);
    drain_results();

    first_phase = 1'b1;
    while (num_words < RANDOM_WORDS) begin
      mix = first_phase ? MIX_GROW : mix_e'($urandom_range(0, 3));
      phase_len = first_phase ? 110 : $urandom_range(20, 80);
      first_phase = 1'b0;
      repeat (phase_len) begin
        if (num_words >= RANDOM_WORDS) break;
        calm <= (num_words >= 450 && num_words < 650);
        if (num_words >= 750) hold_req <= 1'b1;
        op = pick_op(mix);
        send_word(op, pick_position(op), pick_value());
      end
      if ($urandom_range(0, 4) == 0) drain_results();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** positional_array_list: PASSED **");
    end else begin
      $display("** positional_array_list: FAILED **");
    end
    $finish;
  end

endmodule
